// ===== src/sula_pkg.sv =====
// Package for the SET/UA link set-up block: frame constants, opcodes,
// register indexes, phase encoding and the result descriptor type.
// No dependencies.
package sula_pkg;

  localparam int FRAME_BYTES = 5;
  localparam int IDX_W       = $clog2(FRAME_BYTES);

  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] CTRL_SET  = 8'h03;
  localparam logic [7:0] CTRL_UA   = 8'h07;

  // Item kinds.
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ADDR    = 2'd0;
  localparam logic [1:0] CFG_TIMEOUT = 2'd1;
  localparam logic [1:0] CFG_MAXATT  = 2'd2;

  // Reported link status codes.
  localparam logic [1:0] STAT_IDLE = 2'd0;
  localparam logic [1:0] STAT_WAIT = 2'd1;
  localparam logic [1:0] STAT_CONN = 2'd2;
  localparam logic [1:0] STAT_FAIL = 2'd3;

  // UA recognizer steps.
  localparam logic [2:0] MS_FLAG0 = 3'd0;
  localparam logic [2:0] MS_ADDR  = 3'd1;
  localparam logic [2:0] MS_CTRL  = 3'd2;
  localparam logic [2:0] MS_CHECK = 3'd3;
  localparam logic [2:0] MS_FLAG1 = 3'd4;

  localparam logic [7:0]  RST_ADDR    = 8'd3;
  localparam logic [15:0] RST_TIMEOUT = 16'd3;
  localparam logic [3:0]  RST_MAXATT  = 4'd3;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_WAIT = 4'b0010,
    PH_CONN = 4'b0100,
    PH_FAIL = 4'b1000
  } phase_t;

  // One queued result group: either a whole SET frame or a single status word.
  typedef struct packed {
    logic       sent;
    logic [7:0] addr;
    logic [1:0] status;
    logic [3:0] attempts;
  } desc_t;

  function automatic logic [1:0] phase_status(input phase_t ph);
    logic [1:0] s;
    s = STAT_IDLE;
    unique case (ph)
      PH_IDLE: s = STAT_IDLE;
      PH_WAIT: s = STAT_WAIT;
      PH_CONN: s = STAT_CONN;
      PH_FAIL: s = STAT_FAIL;
      default: s = STAT_IDLE;
    endcase
    return s;
  endfunction

endpackage

// ===== src/set_ua_link_establish.sv =====
// SET/UA link set-up sender: protocol state, UA recognizer and result queue.
// Depends on sula_pkg.
//
// One input item is taken per cycle; its state update happens at the input
// transfer and its results go into a two-entry result queue. A start item, or
// a tick that expires the timer, yields the five SET frame bytes on five
// consecutive output transfers if attempts are left; every other item yields
// one status result. The output side therefore limits the sustained item rate.
// The input stalls only while both queue entries are occupied.
module set_ua_link_establish (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_tx_byte,
  output logic        out_tx_valid,
  output logic [1:0]  out_link_status,
  output logic [3:0]  out_attempts_used,
  output logic        out_last
);

  logic [7:0]  link_address_r;
  logic [15:0] timeout_ticks_r;
  logic [3:0]  max_attempts_r;

  sula_pkg::phase_t phase_r, phase_nxt;
  logic [2:0]  match_step_r, match_step_nxt;
  logic [3:0]  attempt_r, attempt_nxt;
  logic [15:0] ticks_r, ticks_nxt;

  sula_pkg::desc_t desc_q_r [2];
  sula_pkg::desc_t desc_new;
  logic            wr_ptr_r, rd_ptr_r;
  logic [1:0]      cnt_r;
  logic [sula_pkg::IDX_W-1:0] idx_r;

  logic in_fire, out_fire, grp_done;
  logic do_emit, sent;
  logic [3:0]  att_base;
  logic [15:0] ticks_dec;
  logic [7:0]  check;
  sula_pkg::desc_t head;

  assign in_stall = (cnt_r == 2'd2);
  assign in_fire  = in_valid && !in_stall;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_address_r  <= sula_pkg::RST_ADDR;
      timeout_ticks_r <= sula_pkg::RST_TIMEOUT;
      max_attempts_r  <= sula_pkg::RST_MAXATT;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        sula_pkg::CFG_ADDR:    link_address_r  <= cfg_wdata[7:0];
        sula_pkg::CFG_TIMEOUT: timeout_ticks_r <= cfg_wdata;
        sula_pkg::CFG_MAXATT:  max_attempts_r  <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  assign ticks_dec = (ticks_r != 16'd0) ? ticks_r - 16'd1 : 16'd0;
  assign check     = link_address_r ^ sula_pkg::CTRL_UA;

  // Item processing.
  always_comb begin
    phase_nxt      = phase_r;
    match_step_nxt = match_step_r;
    attempt_nxt    = attempt_r;
    ticks_nxt      = ticks_r;
    do_emit        = 1'b0;
    att_base       = attempt_r;
    sent           = 1'b0;

    case (in_op)
      sula_pkg::OP_START: begin
        do_emit        = 1'b1;
        att_base       = 4'd0;
        match_step_nxt = sula_pkg::MS_FLAG0;
      end
      sula_pkg::OP_BYTE: begin
        if (phase_r == sula_pkg::PH_WAIT) begin
          unique case (match_step_r)
            sula_pkg::MS_FLAG0: begin
              if (in_rx_byte == sula_pkg::FLAG_BYTE) match_step_nxt = sula_pkg::MS_ADDR;
            end
            sula_pkg::MS_ADDR: begin
              if (in_rx_byte == link_address_r) match_step_nxt = sula_pkg::MS_CTRL;
              else if (in_rx_byte != sula_pkg::FLAG_BYTE) match_step_nxt = sula_pkg::MS_FLAG0;
            end
            sula_pkg::MS_CTRL: begin
              if (in_rx_byte == sula_pkg::CTRL_UA) match_step_nxt = sula_pkg::MS_CHECK;
              else if (in_rx_byte == sula_pkg::FLAG_BYTE) match_step_nxt = sula_pkg::MS_ADDR;
              else match_step_nxt = sula_pkg::MS_FLAG0;
            end
            sula_pkg::MS_CHECK: begin
              match_step_nxt = (in_rx_byte == check) ? sula_pkg::MS_FLAG1
                                                     : sula_pkg::MS_FLAG0;
            end
            sula_pkg::MS_FLAG1: begin
              if (in_rx_byte == sula_pkg::FLAG_BYTE) begin
                phase_nxt = sula_pkg::PH_CONN;
                ticks_nxt = 16'd0;
              end
              match_step_nxt = sula_pkg::MS_FLAG0;
            end
            default: match_step_nxt = sula_pkg::MS_FLAG0;
          endcase
        end
      end
      sula_pkg::OP_TICK: begin
        if (phase_r == sula_pkg::PH_WAIT) begin
          ticks_nxt = ticks_dec;
          do_emit   = (ticks_dec == 16'd0);
        end
      end
      default: ;
    endcase

    // The attempt limit is checked before every send.
    if (do_emit) begin
      if (att_base >= max_attempts_r) begin
        phase_nxt      = sula_pkg::PH_FAIL;
        ticks_nxt      = 16'd0;
        match_step_nxt = sula_pkg::MS_FLAG0;
        attempt_nxt    = att_base;
      end else begin
        sent        = 1'b1;
        attempt_nxt = att_base + 4'd1;
        ticks_nxt   = timeout_ticks_r;
        phase_nxt   = sula_pkg::PH_WAIT;
      end
    end

    desc_new.sent     = sent;
    desc_new.addr     = link_address_r;
    desc_new.status   = sula_pkg::phase_status(phase_nxt);
    desc_new.attempts = attempt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= sula_pkg::PH_IDLE;
      match_step_r <= sula_pkg::MS_FLAG0;
      attempt_r    <= 4'd0;
      ticks_r      <= 16'd0;
    end else if (in_fire) begin
      phase_r      <= phase_nxt;
      match_step_r <= match_step_nxt;
      attempt_r    <= attempt_nxt;
      ticks_r      <= ticks_nxt;
    end
  end

  // Result queue and output sequencing.
  assign head      = desc_q_r[rd_ptr_r];
  assign out_valid = (cnt_r != 2'd0);
  assign out_fire  = out_valid && !out_stall;
  assign out_last  = !head.sent || (idx_r == sula_pkg::IDX_W'(sula_pkg::FRAME_BYTES - 1));
  assign grp_done  = out_fire && out_last;

  always_comb begin
    out_tx_byte = 8'd0;
    if (head.sent) begin
      case (idx_r)
        sula_pkg::IDX_W'(1): out_tx_byte = head.addr;
        sula_pkg::IDX_W'(2): out_tx_byte = sula_pkg::CTRL_SET;
        sula_pkg::IDX_W'(3): out_tx_byte = head.addr ^ sula_pkg::CTRL_SET;
        default:             out_tx_byte = sula_pkg::FLAG_BYTE;
      endcase
    end
  end

  assign out_tx_valid      = head.sent;
  assign out_link_status   = head.status;
  assign out_attempts_used = head.attempts;

  always_ff @(posedge clk) begin
    if (in_fire) desc_q_r[wr_ptr_r] <= desc_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
      idx_r    <= '0;
    end else begin
      if (in_fire) wr_ptr_r <= !wr_ptr_r;
      if (grp_done) begin
        rd_ptr_r <= !rd_ptr_r;
        idx_r    <= '0;
      end else if (out_fire) begin
        idx_r <= idx_r + sula_pkg::IDX_W'(1);
      end
      case ({in_fire, grp_done})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ===== tb/tb_set_ua_link_establish.sv =====
// Testbench for set_ua_link_establish: sends start, byte and tick items, tracks
// the SET/UA link set-up in its own model and checks every result transfer.
// Depends on sula_pkg and the set_ua_link_establish RTL.
module tb_set_ua_link_establish;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int HOLD_CYCLES  = 120;
  localparam int STALL_LIMIT  = 1000;
  localparam int RANDOM_ITEMS = 20;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic [1:0] status;
    logic [3:0] attempts;
    logic       last;
  } link_result_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = sula_pkg::CFG_ADDR;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_op = sula_pkg::OP_TICK;
  logic [7:0]  in_rx_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_tx_byte;
  logic        out_tx_valid;
  logic [1:0]  out_link_status;
  logic [3:0]  out_attempts_used;
  logic        out_last;

  set_ua_link_establish u_dut (.*);

  // Model of the link set-up: register copies and protocol state.
  logic [7:0]  reg_link_addr = sula_pkg::RST_ADDR;
  logic [15:0] reg_timeout = sula_pkg::RST_TIMEOUT;
  logic [3:0]  reg_max_att = sula_pkg::RST_MAXATT;
  logic [1:0]  link_status = sula_pkg::STAT_IDLE;
  logic [2:0]  ua_step = sula_pkg::MS_FLAG0;
  logic [3:0]  sets_sent = '0;
  logic [15:0] ticks_remaining = '0;

  link_result_t pending_link_results[$];

  int  mismatches = 0;
  int  results_seen = 0;
  int  items_sent = 0;
  int  quiet_cycles = 0;
  bit  idle_on = 1'b1;
  bit  hold_req = 1'b0;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // The attempt limit is checked before each SET goes out.
  function automatic bit issue_set_frame();
    if (sets_sent >= reg_max_att) begin
      link_status = sula_pkg::STAT_FAIL;
      ticks_remaining = '0;
      ua_step = sula_pkg::MS_FLAG0;
      return 1'b0;
    end
    sets_sent = sets_sent + 4'd1;
    ticks_remaining = reg_timeout;
    link_status = sula_pkg::STAT_WAIT;
    return 1'b1;
  endfunction

  function automatic void link_setup_step(input logic [1:0] op, input logic [7:0] rx);
    logic         sent;
    logic [7:0]   frame [sula_pkg::FRAME_BYTES];
    link_result_t r;
    int           n;
    sent = 1'b0;
    case (op)
      sula_pkg::OP_START: begin
        sets_sent = '0;
        ua_step = sula_pkg::MS_FLAG0;
        sent = issue_set_frame();
      end
      sula_pkg::OP_BYTE: begin
        if (link_status == sula_pkg::STAT_WAIT) begin
          case (ua_step)
            sula_pkg::MS_FLAG0: begin
              if (rx == sula_pkg::FLAG_BYTE) ua_step = sula_pkg::MS_ADDR;
            end
            sula_pkg::MS_ADDR: begin
              if (rx == reg_link_addr) ua_step = sula_pkg::MS_CTRL;
              else if (rx != sula_pkg::FLAG_BYTE) ua_step = sula_pkg::MS_FLAG0;
            end
            sula_pkg::MS_CTRL: begin
              if (rx == sula_pkg::CTRL_UA) ua_step = sula_pkg::MS_CHECK;
              else if (rx == sula_pkg::FLAG_BYTE) ua_step = sula_pkg::MS_ADDR;
              else ua_step = sula_pkg::MS_FLAG0;
            end
            sula_pkg::MS_CHECK: begin
              // Any wrong check byte, a flag included, goes back to the start.
              ua_step = (rx == (reg_link_addr ^ sula_pkg::CTRL_UA)) ? sula_pkg::MS_FLAG1
                                                                     : sula_pkg::MS_FLAG0;
            end
            default: begin
              if (ua_step == sula_pkg::MS_FLAG1 && rx == sula_pkg::FLAG_BYTE) begin
                link_status = sula_pkg::STAT_CONN;
                ticks_remaining = '0;
              end
              ua_step = sula_pkg::MS_FLAG0;
            end
          endcase
        end
      end
      sula_pkg::OP_TICK: begin
        if (link_status == sula_pkg::STAT_WAIT) begin
          if (ticks_remaining != 0) ticks_remaining = ticks_remaining - 16'd1;
          if (ticks_remaining == 0) sent = issue_set_frame();
        end
      end
      default: begin
      end
    endcase
    frame[0] = sula_pkg::FLAG_BYTE;
    frame[1] = reg_link_addr;
    frame[2] = sula_pkg::CTRL_SET;
    frame[3] = reg_link_addr ^ sula_pkg::CTRL_SET;
    frame[4] = sula_pkg::FLAG_BYTE;
    n = sent ? sula_pkg::FRAME_BYTES : 1;
    for (int k = 0; k < n; k++) begin
      r.tx_byte = sent ? frame[k] : 8'h00;
      r.tx_valid = sent;
      r.status = link_status;
      r.attempts = sets_sent;
      r.last = (k == n - 1);
      pending_link_results.push_back(r);
    end
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                results_seen, name, got, want));
  endtask

  // Valid stays high after a transfer; only a gap or settle_link lowers it.
  task automatic send_item(input logic [1:0] op, input logic [7:0] rx);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_rx_byte <= rx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    link_setup_step(op, rx);
    items_sent++;
  endtask

  // Sends a UA frame for the current address, with one byte replaced if bad_pos
  // names a position in the frame.
  task automatic send_ua_frame(input int bad_pos, input logic [7:0] bad_val);
    logic [7:0] ua [sula_pkg::FRAME_BYTES];
    ua[0] = sula_pkg::FLAG_BYTE;
    ua[1] = reg_link_addr;
    ua[2] = sula_pkg::CTRL_UA;
    ua[3] = reg_link_addr ^ sula_pkg::CTRL_UA;
    ua[4] = sula_pkg::FLAG_BYTE;
    for (int k = 0; k < sula_pkg::FRAME_BYTES; k++)
      send_item(sula_pkg::OP_BYTE, (k == bad_pos) ? bad_val : ua[k]);
  endtask

  task automatic settle_link();
    in_valid <= 1'b0;
    while (pending_link_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_config(input logic [7:0] addr, input logic [15:0] tmo,
                              input logic [3:0] att);
    cfg_wr_en <= 1'b1;
    cfg_index <= sula_pkg::CFG_ADDR;
    cfg_wdata <= {8'h00, addr};
    @(posedge clk);
    cfg_index <= sula_pkg::CFG_TIMEOUT;
    cfg_wdata <= tmo;
    @(posedge clk);
    cfg_index <= sula_pkg::CFG_MAXATT;
    cfg_wdata <= {12'h000, att};
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    reg_link_addr = addr;
    reg_timeout = tmo;
    reg_max_att = att;
  endtask

  // One set-up attempt under a fresh configuration: mostly UA frames and ticks,
  // with corrupted frames, stray bytes, unused items and restarts mixed in.
  task automatic run_session(input int actions);
    logic [7:0]  addr;
    logic [15:0] tmo;
    logic [3:0]  att;
    int          pick;
    case ($urandom_range(0, 3))
      0: addr = 8'h00;
      1: addr = 8'hFF;
      default: addr = 8'($urandom_range(0, 255));
    endcase
    case ($urandom_range(0, 9))
      0: tmo = 16'd0;
      1: tmo = 16'hFFFF;
      2: tmo = 16'($urandom_range(0, 65535));
      default: tmo = 16'($urandom_range(1, 3));
    endcase
    case ($urandom_range(0, 7))
      0: att = 4'd0;
      1: att = 4'd15;
      default: att = 4'($urandom_range(1, 4));
    endcase
    settle_link();
    write_config(addr, tmo, att);
    send_item(sula_pkg::OP_START, 8'($urandom_range(0, 255)));
    repeat (actions) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        if ($urandom_range(0, 3) == 0)
          send_ua_frame($urandom_range(0, 4), 8'($urandom_range(0, 255)));
        else send_ua_frame(-1, 8'h00);
      end else if (pick < 70) begin
        repeat ($urandom_range(1, 3)) send_item(sula_pkg::OP_TICK, 8'($urandom_range(0, 255)));
      end else if (pick < 75) begin
        // Long tick run so that high attempt limits are actually reached.
        repeat ($urandom_range(4, 16)) send_item(sula_pkg::OP_TICK, 8'($urandom_range(0, 255)));
      end else if (pick < 88) begin
        send_item(sula_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
      end else if (pick < 94) begin
        send_item(OP_UNUSED, 8'($urandom_range(0, 255)));
      end else begin
        send_item(sula_pkg::OP_START, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic test_ignored_items();
    send_item(sula_pkg::OP_TICK, 8'h00);
    send_item(sula_pkg::OP_BYTE, 8'hFF);
    send_item(OP_UNUSED, sula_pkg::FLAG_BYTE);
  endtask

  // Runs on the register values left by reset.
  task automatic test_connect_and_fallbacks();
    send_item(sula_pkg::OP_START, 8'h00);
    send_ua_frame(3, sula_pkg::FLAG_BYTE);
    send_ua_frame(4, 8'h00);
    send_ua_frame(-1, 8'h00);
    send_item(sula_pkg::OP_TICK, 8'hFF);
    send_item(sula_pkg::OP_START, 8'hFF);
  endtask

  task automatic test_retry_and_failure();
    settle_link();
    write_config(8'hFF, 16'd0, 4'd2);
    send_item(sula_pkg::OP_START, 8'h00);
    send_item(sula_pkg::OP_START, 8'h00);
    send_item(sula_pkg::OP_TICK, 8'h00);
    send_item(sula_pkg::OP_TICK, 8'h00);
    send_item(sula_pkg::OP_BYTE, sula_pkg::FLAG_BYTE);
  endtask

  task automatic test_zero_attempt_limit();
    settle_link();
    write_config(8'h00, 16'hFFFF, 4'd0);
    send_item(sula_pkg::OP_START, 8'h00);
  endtask

  task automatic test_random_sessions();
    int first_item;
    first_item = items_sent;
    while (items_sent - first_item < RANDOM_ITEMS) run_session($urandom_range(3, 10));
  endtask

  // The receiver holds off while items keep coming, so the input backs up.
  task automatic test_output_holdoff();
    idle_on = 1'b0;
    hold_req = 1'b1;
    run_session(8);
  endtask

  task automatic test_steady_stream();
    idle_on = 1'b0;
    repeat (2) run_session(6);
  endtask

  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_results
    link_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_link_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                  results_seen));
      end else begin
        want = pending_link_results.pop_front();
        check_field("tx_byte", 16'(out_tx_byte), 16'(want.tx_byte));
        check_field("tx_valid", 16'(out_tx_valid), 16'(want.tx_valid));
        check_field("link_status", 16'(out_link_status), 16'(want.status));
        check_field("attempts_used", 16'(out_attempts_used), 16'(want.attempts));
        check_field("last", 16'(out_last), 16'(want.last));
      end
    end
  end

  // Counts cycles without any transfer on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_ignored_items();
    test_connect_and_fallbacks();
    test_retry_and_failure();
    test_zero_attempt_limit();
    test_random_sessions();
    test_output_holdoff();
    test_steady_stream();
    settle_link();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
